@@ hw/rtl/shs_pkg.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher package
// Shared types, round constants, initial hash values and the SHA-256
// bit functions used by the core and its compression engine.
// ----------------------------------------------------------------------------
package shs_pkg;

  typedef enum logic [2:0] {
    SHS_IDLE,
    SHS_BLK,
    SHS_PAD,
    SHS_PADC,
    SHS_OUT
  } shs_state_t;

  // Commands from the sequencer to the compression engine.
  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic       start;
    logic       chain_init;
  } shs_ctrl_t;

  localparam logic [7:0] SHS_PAD_MARK = 8'h80;

  localparam logic [31:0] SHS_K [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHS_IV [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] shs_bsig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] shs_bsig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] shs_ssig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] shs_ssig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

@@ hw/rtl/shs_compress.sv @@
// ----------------------------------------------------------------------------
// SHA-256 compression engine
// Holds the chaining words, the 16-word block window and the working
// variables, and runs one round per cycle over a block on request.
// ----------------------------------------------------------------------------
module shs_compress (
  input  logic              clk,
  input  logic              rst_n,
  input  shs_pkg::shs_ctrl_t ctrl,
  input  logic [2:0]        dig_idx,
  output logic [31:0]       dig_word,
  output logic              done
);

  logic [31:0] h_r [0:7];
  logic [31:0] v_r [0:7];
  logic [31:0] w_r [0:15];
  logic [5:0]  cnt_r;
  logic        run_r;
  logic        fin_r;

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] w_new;
  logic [4:0]  lane_lsb;

  always_comb begin
    t1 = v_r[7] + shs_pkg::shs_bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
         + shs_pkg::SHS_K[cnt_r] + w_r[0];
    t2 = shs_pkg::shs_bsig0(v_r[0])
         + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
    w_new = shs_pkg::shs_ssig1(w_r[14]) + w_r[9] + shs_pkg::shs_ssig0(w_r[1]) + w_r[0];
    // Byte 0 of a word is its most significant byte.
    lane_lsb = {~ctrl.wr_pos[1:0], 3'b000};
  end

  assign dig_word = h_r[dig_idx];
  assign done     = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      fin_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      fin_r <= 1'b0;
      if (ctrl.start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= shs_pkg::SHS_IV[i];
      end
    end else if (ctrl.chain_init) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= shs_pkg::SHS_IV[i];
      end
    end else if (fin_r) begin
      for (int i = 0; i < 8; i++) begin
        h_r[i] <= h_r[i] + v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      for (int i = 0; i < 8; i++) begin
        v_r[i] <= h_r[i];
      end
    end else if (run_r) begin
      v_r[0] <= t1 + t2;
      v_r[1] <= v_r[0];
      v_r[2] <= v_r[1];
      v_r[3] <= v_r[2];
      v_r[4] <= v_r[3] + t1;
      v_r[5] <= v_r[4];
      v_r[6] <= v_r[5];
      v_r[7] <= v_r[6];
    end
  end

  // The window slides by one word per round; its head is the schedule word.
  always_ff @(posedge clk) begin
    if (run_r) begin
      for (int i = 0; i < 15; i++) begin
        w_r[i] <= w_r[i+1];
      end
      w_r[15] <= w_new;
    end else if (ctrl.wr_en) begin
      w_r[ctrl.wr_pos[5:2]][lane_lsb +: 8] <= ctrl.wr_byte;
    end
  end

endmodule

@@ hw/rtl/sha256_stream_hasher_core.sv @@
// A byte that does not fill a block is taken without holding off the input; a byte that fills
// one holds the input off while it is compressed (64 rounds and a final add).
// A last item pads one byte per cycle to the block end, compresses, possibly
// twice, then offers the 8 digest words, one per output transfer.
// The single round unit sets throughput: no byte is taken during a compression.
// Reset loads the initial hash values and clears the length.
// ----------------------------------------------------------------------------
// SHA-256 stream hasher core
// Byte-serial SHA-256 with standard padding and an eight-word digest output.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_message_byte,
  input  logic        in_has_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  shs_pkg::shs_state_t state_r, state_nxt;
  logic [60:0] count_r, count_nxt;
  logic [5:0]  pad_pos_r, pad_pos_nxt;
  logic        mark_r, mark_nxt;
  logic        len_here_r, len_here_nxt;
  logic        fin_r, fin_nxt;
  logic [2:0]  idx_r, idx_nxt;

  shs_pkg::shs_ctrl_t ctrl;
  logic        done;
  logic [31:0] dig_word;
  logic [63:0] len_bits;
  logic [5:0]  pad_start;
  logic [2:0]  len_lane;
  logic [7:0]  len_byte;

  shs_compress u_compress (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .dig_idx  (idx_r),
    .dig_word (dig_word),
    .done     (done)
  );

  assign in_stall        = (state_r != shs_pkg::SHS_IDLE);
  assign out_valid       = (state_r == shs_pkg::SHS_OUT);
  assign out_digest_word = dig_word;
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= shs_pkg::SHS_IDLE;
      count_r    <= '0;
      pad_pos_r  <= '0;
      mark_r     <= 1'b0;
      len_here_r <= 1'b0;
      fin_r      <= 1'b0;
      idx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      pad_pos_r  <= pad_pos_nxt;
      mark_r     <= mark_nxt;
      len_here_r <= len_here_nxt;
      fin_r      <= fin_nxt;
      idx_r      <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    pad_pos_nxt  = pad_pos_r;
    mark_nxt     = mark_r;
    len_here_nxt = len_here_r;
    fin_nxt      = fin_r;
    idx_nxt      = idx_r;
    ctrl         = '0;

    // The bit length is the byte count times eight, sent most significant first.
    len_bits  = {count_r, 3'b000};
    len_lane  = 3'd7 - pad_pos_r[2:0];
    len_byte  = len_bits[{len_lane, 3'b000} +: 8];
    pad_start = in_has_byte ? (count_r[5:0] + 6'd1) : count_r[5:0];

    case (state_r)
      shs_pkg::SHS_IDLE: begin
        if (in_valid) begin
          fin_nxt      = in_last;
          pad_pos_nxt  = pad_start;
          mark_nxt     = 1'b1;
          // When the mark lands in the last eight bytes, the length needs a
          // second block.
          len_here_nxt = (pad_start[5:3] != 3'b111);
          if (in_has_byte) begin
            ctrl.wr_en   = 1'b1;
            ctrl.wr_pos  = count_r[5:0];
            ctrl.wr_byte = in_message_byte;
            count_nxt    = count_r + 61'd1;
          end
          if (in_has_byte && (count_r[5:0] == 6'd63)) begin
            ctrl.start = 1'b1;
            state_nxt  = shs_pkg::SHS_BLK;
          end else if (in_last) begin
            state_nxt = shs_pkg::SHS_PAD;
          end
        end
      end
      shs_pkg::SHS_BLK: begin
        if (done) begin
          state_nxt = fin_r ? shs_pkg::SHS_PAD : shs_pkg::SHS_IDLE;
        end
      end
      shs_pkg::SHS_PAD: begin
        ctrl.wr_en  = 1'b1;
        ctrl.wr_pos = pad_pos_r;
        if (mark_r) begin
          ctrl.wr_byte = shs_pkg::SHS_PAD_MARK;
        end else if (len_here_r && (pad_pos_r[5:3] == 3'b111)) begin
          ctrl.wr_byte = len_byte;
        end else begin
          ctrl.wr_byte = 8'h00;
        end
        mark_nxt    = 1'b0;
        pad_pos_nxt = pad_pos_r + 6'd1;
        if (pad_pos_r == 6'd63) begin
          ctrl.start = 1'b1;
          state_nxt  = shs_pkg::SHS_PADC;
        end
      end
      shs_pkg::SHS_PADC: begin
        if (done) begin
          if (len_here_r) begin
            idx_nxt   = 3'd0;
            state_nxt = shs_pkg::SHS_OUT;
          end else begin
            pad_pos_nxt  = 6'd0;
            len_here_nxt = 1'b1;
            state_nxt    = shs_pkg::SHS_PAD;
          end
        end
      end
      shs_pkg::SHS_OUT: begin
        if (!out_stall) begin
          if (idx_r == 3'd7) begin
            ctrl.chain_init = 1'b1;
            count_nxt       = '0;
            state_nxt       = shs_pkg::SHS_IDLE;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = shs_pkg::SHS_IDLE;
      end
    endcase
  end

endmodule

@@ hw/rtl/shs_checker.sv @@
// ----------------------------------------------------------------------------
// SHA-256 stream hasher port checker
// Watches the core's ports for digest sequencing and input hold-off.
// ----------------------------------------------------------------------------
module shs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       in_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] out_word_index,
  input logic       out_last_word
);

  // No new input is taken while a digest is being delivered.
  a_out_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_index == 3'd7)))
    else $error("last_word does not match word index");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_word) |=>
      (out_valid && (out_word_index == $past(out_word_index) + 3'd1)))
    else $error("digest word index did not advance");

  a_ready_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_word) |=> (!out_valid && !in_stall))
    else $error("core not ready after final digest transfer");

  a_last_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last) |=> in_stall)
    else $error("last item did not start padding");

endmodule

bind sha256_stream_hasher_core shs_checker u_shs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_last        (in_last),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_word_index (out_word_index),
  .out_last_word  (out_last_word)
);

@@ tb/digest_check_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 digest scoreboard
// Holds a bit-exact SHA-256 predictor fed with every accepted input transfer.
// It queues the eight digest words each message end produces and compares them
// with the words the core delivers.
// ----------------------------------------------------------------------------
package digest_check_pkg;

  localparam bit [31:0] ROUND_CONST [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam bit [31:0] START_HASH [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam bit [7:0] PAD_BYTE = 8'h80;
  localparam int MAX_PRINTED = 30;

  typedef struct {
    bit [31:0] word;
    bit [2:0]  index;
    bit        last_word;
  } digest_word_t;

  class digest_scoreboard;
    bit [31:0]    chain [8];
    bit [7:0]     block_bytes [64];
    bit [60:0]    byte_total;
    digest_word_t digest_q [$];
    int           errors;
    int           words_checked;
    int           messages_done;
    int           empty_messages;
    int           two_block_pads;
    int           bytes_hashed;

    function new();
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
      byte_total = '0;
    endfunction

    function bit [31:0] rotr(bit [31:0] v, int unsigned s);
      return (v >> s) | (v << (32 - s));
    endfunction

    function void compress_block();
      bit [31:0] w [64];
      bit [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
      for (int t = 0; t < 16; t++)
        w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
      for (int t = 16; t < 64; t++) begin
        s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
        s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
        w[t] = s1 + w[t-7] + s0 + w[t-16];
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
        t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
             + ROUND_CONST[t] + w[t];
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
        h = g; g = f; f = e; e = d + t1;
        d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endfunction

    // Called once per accepted input transfer.
    function void note_item(bit [7:0] data, bit has, bit fin);
      int unsigned  pos;
      bit [63:0]    bit_len;
      digest_word_t nxt;
      if (has) begin
        pos = byte_total[5:0];
        block_bytes[pos] = data;
        byte_total++;
        bytes_hashed++;
        if (pos == 63) compress_block();
      end
      if (!fin) return;
      if (byte_total == 0) empty_messages++;
      pos = byte_total[5:0];
      block_bytes[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
      // No room left for the length field: spill it into an extra block.
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 56; i++) block_bytes[i] = 8'h00;
        two_block_pads++;
      end
      bit_len = {byte_total, 3'b000};
      for (int i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        nxt.word = chain[i];
        nxt.index = i[2:0];
        nxt.last_word = (i == 7);
        digest_q.push_back(nxt);
      end
      messages_done++;
      restart();
    endfunction

    task report_mismatch(string msg);
      if (errors < MAX_PRINTED) $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_word(logic [31:0] word, logic [2:0] index, logic last_word);
      digest_word_t ref_w;
      if (digest_q.size() == 0) begin
        report_mismatch($sformatf("digest word %h index %0d with none pending", word, index));
        return;
      end
      ref_w = digest_q.pop_front();
      words_checked++;
      if (word !== ref_w.word)
        report_mismatch($sformatf("word %0d: got %h, want %h", ref_w.index, word, ref_w.word));
      if (index !== ref_w.index)
        report_mismatch($sformatf("index: got %0d, want %0d", index, ref_w.index));
      if (last_word !== ref_w.last_word)
        report_mismatch($sformatf("word %0d: last flag got %b, want %b",
                                  ref_w.index, last_word, ref_w.last_word));
    endtask

    function int pending();
      return digest_q.size();
    endfunction
  endclass

endpackage

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Feeds byte-serial messages (empty, short, and lengths around the padding
// boundaries) with random idle and stall cycles on both sides, and checks
// every digest word against the scoreboard's predicted digest.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 500;
  localparam int ITEM_TARGET = 160;
  localparam int MIN_MESSAGES = 6;
  localparam int DRAIN_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_message_byte = 8'h00;
  logic        in_has_byte = 1'b0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  digest_check_pkg::digest_scoreboard board = new();
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  int  cycles = 0;
  int  items_counted = 0;

  sha256_stream_hasher_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_message_byte (in_message_byte),
    .in_has_byte     (in_has_byte),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d digest words pending", cycles, board.pending());
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: values read right after the edge are the ones the edge saw.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall)
        board.check_word(out_digest_word, out_word_index, out_last_word);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 35);
      end
    end
  end

  task automatic send_item(input logic [7:0] data, input logic has, input logic fin);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      in_message_byte <= 8'($urandom_range(255));
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_message_byte <= data;
    in_has_byte <= has;
    in_last <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(data, has, fin);
    items_counted++;
  endtask

  // A message either ends on its final byte or with a separate byteless end.
  task automatic send_message(input int unsigned len, input bit bare_end);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !bare_end);
    end
    if (bare_end || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned boundary_len [6];
    int unsigned len;
    int          msg_no;
    boundary_len = '{55, 56, 57, 63, 64, 65};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty message, extreme bytes, ignored transfers, short text.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'h80, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h7f, 1'b0, 1'b0);

    // Random messages, the first two forced onto the padding boundaries.
    msg_no = 0;
    while (items_counted < ITEM_TARGET || msg_no < MIN_MESSAGES) begin
      if (msg_no == 0) len = 56;
      else if (msg_no == 1) len = 64;
      else if ($urandom_range(3) == 0) len = boundary_len[$urandom_range(5)];
      else len = $urandom_range(12);
      steady = (msg_no == 1 || msg_no == 2);
      if (msg_no == 4) hold_req = 1'b1;
      send_message(len, $urandom_range(2) == 0);
      msg_no++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    while (board.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Hashed %0d messages (%0d empty, %0d needing an extra pad block), %0d bytes.",
             board.messages_done, board.empty_messages, board.two_block_pads,
             board.bytes_hashed);
    $display("Checked %0d digest words, %0d mismatches.", board.words_checked, board.errors);
    if (board.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sha256_stream_hasher_core.f @@
hw/rtl/shs_pkg.sv
hw/rtl/shs_compress.sv
hw/rtl/sha256_stream_hasher_core.sv
hw/rtl/shs_checker.sv
tb/digest_check_pkg.sv
tb/testbench.sv
